// ===== hw/rtl/stps_pkg.sv =====
`default_nettype none

package stps_pkg;

	localparam int unsigned CoordWidth = 16;
	localparam int unsigned PosWidth   = 32;
	localparam int unsigned VelWidth   = 16;
	localparam int unsigned TimeWidth  = 16;
	localparam int unsigned OpWidth    = 2;
	localparam int unsigned RegIdxWidth = 1;

	localparam logic [OpWidth-1:0] OP_TICK       = 2'd0;
	localparam logic [OpWidth-1:0] OP_SET_POS    = 2'd1;
	localparam logic [OpWidth-1:0] OP_SET_TARGET = 2'd2;

	localparam logic [RegIdxWidth-1:0] REG_VELOCITY_X = 1'd0;
	localparam logic [RegIdxWidth-1:0] REG_VELOCITY_Y = 1'd1;

	// 0.2 in unsigned q8.8
	localparam logic [VelWidth-1:0] VEL_RESET = 16'd51;

endpackage

`default_nettype wire

// ===== hw/rtl/stps_item_if.sv =====
`default_nettype none

interface stps_item_if;
	logic                                valid;
	logic                                ready;
	logic [stps_pkg::OpWidth-1:0]        opcode;
	logic [stps_pkg::TimeWidth-1:0]      time_step;
	logic signed [stps_pkg::CoordWidth-1:0] coord_x;
	logic signed [stps_pkg::CoordWidth-1:0] coord_y;

	modport source (output valid, output opcode, output time_step, output coord_x,
		output coord_y, input ready);
	modport sink (input valid, input opcode, input time_step, input coord_x,
		input coord_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stps_result_if.sv =====
`default_nettype none

interface stps_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [stps_pkg::PosWidth-1:0] position_x;
	logic signed [stps_pkg::PosWidth-1:0] position_y;
	logic                                 reached;
	logic                                 bad_time;

	modport source (output valid, output position_x, output position_y, output reached,
		output bad_time, input ready);
	modport sink (input valid, input position_x, input position_y, input reached,
		input bad_time, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stps_cfg_if.sv =====
`default_nettype none

interface stps_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [stps_pkg::RegIdxWidth-1:0]      reg_index;
	logic [stps_pkg::VelWidth-1:0]         wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/seek_target_position_step_top.sv =====
// channel     dir  handshake     payload
// item_in     in   valid/ready   opcode, time_step, coord_x, coord_y
// result_out  out  valid/ready   position_x, position_y, reached, bad_time
// cfg         in   valid/ready   reg_index, wdata (always ready)
//
// items that do not move go straight to the output load. a moving tick runs difference and
// magnitude, sum of squares, root, then per axis setup, unit divide, velocity multiply,
// time divide and move, and last the output load; zero length stops after the root.
// item_in.ready is low while an item is in flight; a result waits in the output register
// and the next item is taken meanwhile. reset sets velocities to 0.2
`default_nettype none

module seek_target_position_step_top (
	input  wire                  clk,
	input  wire                  arst_n,
	stps_item_if.sink            item_in,
	stps_result_if.source        result_out,
	stps_cfg_if.sink             cfg
);

	localparam int unsigned AW = 67;

	typedef enum logic [3:0] {
		S_IDLE, S_DX, S_DY, S_AX, S_AY, S_SQ, S_RT, S_AXIS, S_UD, S_MU, S_TD, S_MV, S_DONE
	} state_t;

	state_t       state_q;
	logic [5:0]   cnt_q;
	logic         axis_q;
	logic         bad_q;
	logic         tv_q;
	logic [31:0]  pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
	logic [15:0]  vel_x_q, vel_y_q;
	logic [15:0]  t_q;

	logic         out_valid_q;
	logic [31:0]  out_x_q, out_y_q;
	logic         out_reached_q, out_bad_q;

	logic [32:0]  dx_q, dy_q, ax_q, ay_q;
	logic [65:0]  acc_q;
	logic [35:0]  rem_q;
	logic [32:0]  root_q;
	logic [31:0]  quo_q;

	logic [AW-1:0] alu_a, alu_b, alu_c, alu_res;
	logic          alu_ge;
	logic [35:0]   rs_rt;
	logic [34:0]   trial;
	logic [33:0]   rs_ud;
	logic [16:0]   rs_td;
	logic [32:0]   mag;
	logic          neg;
	logic [15:0]   vel;
	logic [31:0]   pos_cur;
	logic [31:0]   pos_new;
	logic [33:0]   sum34;
	logic          accept;

	assign accept = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign mag     = axis_q ? ay_q : ax_q;
	assign neg     = axis_q ? dy_q[32] : dx_q[32];
	assign vel     = axis_q ? vel_y_q : vel_x_q;
	assign pos_cur = axis_q ? pos_y_q : pos_x_q;

	assign rs_rt = {rem_q[33:0], acc_q[65:64]};
	assign trial = {root_q[32:0], 2'b01};
	// only the first quotient bit pulls in a numerator bit, the rest are zero
	assign rs_ud = {rem_q[32:0], (cnt_q == 6'd30) ? mag[0] : 1'b0};
	assign rs_td = {rem_q[15:0], acc_q[45]};

	// shared adder: subtract is a + ~b + 1
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_c = '0;
		unique case (state_q)
			S_DX: begin
				alu_a = {{35{tgt_x_q[31]}}, tgt_x_q};
				alu_b = ~{{35{pos_x_q[31]}}, pos_x_q};
				alu_c = AW'(1);
			end
			S_DY: begin
				alu_a = {{35{tgt_y_q[31]}}, tgt_y_q};
				alu_b = ~{{35{pos_y_q[31]}}, pos_y_q};
				alu_c = AW'(1);
			end
			S_AX: begin
				if (dx_q[32]) begin
					alu_b = ~{{34{dx_q[32]}}, dx_q};
					alu_c = AW'(1);
				end else begin
					alu_a = {34'd0, dx_q};
				end
			end
			S_AY: begin
				if (dy_q[32]) begin
					alu_b = ~{{34{dy_q[32]}}, dy_q};
					alu_c = AW'(1);
				end else begin
					alu_a = {34'd0, dy_q};
				end
			end
			S_SQ: begin
				alu_a = {acc_q, 1'b0} & {1'b0, {(AW-1){1'b1}}};
				alu_b = ax_q[cnt_q] ? {34'd0, ax_q} : '0;
				alu_c = ay_q[cnt_q] ? {34'd0, ay_q} : '0;
			end
			S_RT: begin
				alu_a = {31'd0, rs_rt};
				alu_b = ~{32'd0, trial};
				alu_c = AW'(1);
			end
			S_UD: begin
				alu_a = {33'd0, rs_ud};
				alu_b = ~{34'd0, root_q};
				alu_c = AW'(1);
			end
			S_MU: begin
				alu_a = {acc_q, 1'b0} & {1'b0, {(AW-1){1'b1}}};
				alu_b = vel[cnt_q[3:0]] ? {36'd0, quo_q[30:0]} : '0;
			end
			S_TD: begin
				alu_a = {50'd0, rs_td};
				alu_b = ~{51'd0, t_q};
				alu_c = AW'(1);
			end
			S_MV: begin
				alu_a = {{35{pos_cur[31]}}, pos_cur};
				alu_b = neg ? ~{35'd0, quo_q} : {35'd0, quo_q};
				alu_c = neg ? AW'(1) : '0;
			end
			default: begin
			end
		endcase
	end

	assign alu_res = alu_a + alu_b + alu_c;
	assign alu_ge  = ~alu_res[AW-1];

	// saturate the moved coordinate to the signed 32-bit range
	assign sum34 = alu_res[33:0];
	always_comb begin
		if (sum34[33:31] == 3'b000 || sum34[33:31] == 3'b111) begin
			pos_new = sum34[31:0];
		end else if (!sum34[33]) begin
			pos_new = 32'h7FFF_FFFF;
		end else begin
			pos_new = 32'h8000_0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			axis_q        <= 1'b0;
			bad_q         <= 1'b0;
			tv_q          <= 1'b0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			tgt_x_q       <= '0;
			tgt_y_q       <= '0;
			vel_x_q       <= stps_pkg::VEL_RESET;
			vel_y_q       <= stps_pkg::VEL_RESET;
			out_valid_q   <= 1'b0;
			out_x_q       <= '0;
			out_y_q       <= '0;
			out_reached_q <= 1'b0;
			out_bad_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.reg_index)
					stps_pkg::REG_VELOCITY_X: vel_x_q <= cfg.wdata;
					stps_pkg::REG_VELOCITY_Y: vel_y_q <= cfg.wdata;
					default: begin
					end
				endcase
			end

			// in S_DONE the output register is reloaded instead
			if (out_valid_q && result_out.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item_in.opcode)
							stps_pkg::OP_TICK: begin
								if (item_in.time_step == '0) begin
									bad_q   <= 1'b1;
									state_q <= S_DONE;
								end else if (tv_q) begin
									bad_q   <= 1'b0;
									state_q <= S_DX;
								end else begin
									bad_q   <= 1'b0;
									state_q <= S_DONE;
								end
							end
							stps_pkg::OP_SET_POS: begin
								bad_q   <= 1'b0;
								state_q <= S_DONE;
								pos_x_q <= {item_in.coord_x, 16'd0};
								pos_y_q <= {item_in.coord_y, 16'd0};
								tgt_x_q <= {item_in.coord_x, 16'd0};
								tgt_y_q <= {item_in.coord_y, 16'd0};
								tv_q    <= 1'b1;
							end
							stps_pkg::OP_SET_TARGET: begin
								bad_q   <= 1'b0;
								state_q <= S_DONE;
								tgt_x_q <= {item_in.coord_x, 16'd0};
								tgt_y_q <= {item_in.coord_y, 16'd0};
								tv_q    <= 1'b1;
							end
							default: begin
								bad_q   <= 1'b0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DX: state_q <= S_DY;
				S_DY: state_q <= S_AX;
				S_AX: state_q <= S_AY;
				S_AY: begin
					state_q <= S_SQ;
					cnt_q   <= 6'd32;
				end
				S_SQ: begin
					if (cnt_q == '0) begin
						state_q <= S_RT;
						cnt_q   <= 6'd32;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_RT: begin
					if (cnt_q == '0) begin
						axis_q  <= 1'b0;
						// zero length: already on target
						state_q <= (root_q == '0 && !alu_ge) ? S_DONE : S_AXIS;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_AXIS: begin
					state_q <= S_UD;
					cnt_q   <= 6'd30;
				end
				S_UD: begin
					if (cnt_q == '0) begin
						state_q <= S_MU;
						cnt_q   <= 6'd15;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_MU: begin
					if (cnt_q == '0) begin
						state_q <= S_TD;
						cnt_q   <= 6'd31;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_TD: begin
					if (cnt_q == '0) begin
						state_q <= S_MV;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_MV: begin
					if (axis_q) begin
						pos_y_q <= pos_new;
						state_q <= S_DONE;
					end else begin
						pos_x_q <= pos_new;
						axis_q  <= 1'b1;
						state_q <= S_AXIS;
					end
				end
				S_DONE: begin
					if (!out_valid_q || result_out.ready) begin
						out_valid_q   <= 1'b1;
						out_x_q       <= pos_x_q;
						out_y_q       <= pos_y_q;
						out_reached_q <= !tv_q || (pos_x_q == tgt_x_q && pos_y_q == tgt_y_q);
						out_bad_q     <= bad_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= item_in.time_step;
		end
		unique case (state_q)
			S_DX: dx_q <= alu_res[32:0];
			S_DY: dy_q <= alu_res[32:0];
			S_AX: ax_q <= alu_res[32:0];
			S_AY: begin
				ay_q  <= alu_res[32:0];
				acc_q <= '0;
			end
			S_SQ: begin
				acc_q <= alu_res[65:0];
				if (cnt_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			S_RT: begin
				acc_q <= {acc_q[63:0], 2'b00};
				if (alu_ge) begin
					rem_q  <= alu_res[35:0];
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rs_rt;
					root_q <= {root_q[31:0], 1'b0};
				end
			end
			S_AXIS: begin
				rem_q <= {4'd0, mag[32:1]};
				quo_q <= '0;
			end
			S_UD: begin
				if (alu_ge) begin
					rem_q <= alu_res[35:0];
				end else begin
					rem_q <= {2'd0, rs_ud};
				end
				quo_q <= {quo_q[30:0], alu_ge};
				if (cnt_q == '0) begin
					acc_q <= '0;
				end
			end
			S_MU: begin
				acc_q <= alu_res[65:0];
				if (cnt_q == '0) begin
					quo_q <= '0;
					rem_q <= '0;
				end
			end
			S_TD: begin
				acc_q <= {acc_q[64:0], 1'b0};
				if (alu_ge) begin
					rem_q <= alu_res[35:0];
				end else begin
					rem_q <= {19'd0, rs_td};
				end
				quo_q <= {quo_q[30:0], alu_ge};
			end
			default: begin
			end
		endcase
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.position_x = out_x_q;
	assign result_out.position_y = out_y_q;
	assign result_out.reached    = out_reached_q;
	assign result_out.bad_time   = out_bad_q;

	a_zero_time_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item_in.opcode == stps_pkg::OP_TICK && item_in.time_step == '0)
		|=> (state_q == S_DONE && bad_q))
		else $error("zero-time tick not flagged");

	a_set_pos_on_target: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item_in.opcode == stps_pkg::OP_SET_POS)
		|=> (tv_q && pos_x_q == tgt_x_q && pos_y_q == tgt_y_q))
		else $error("set-position left position off target");

	a_no_target_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !tv_q) |-> result_out.reached)
		else $error("result without target not reported as reached");

	a_divide_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UD) |-> (root_q != '0))
		else $error("unit divide entered with zero length");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import stps_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [OpWidth-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OpWidth-1:0]           opcode;
		logic [TimeWidth-1:0]         time_step;
		logic signed [CoordWidth-1:0] coord_x;
		logic signed [CoordWidth-1:0] coord_y;
	} seek_item_t;

	typedef struct packed {
		logic signed [PosWidth-1:0] position_x;
		logic signed [PosWidth-1:0] position_y;
		logic                       reached;
		logic                       bad_time;
	} seek_result_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_VELOCITY} row_kind_e;

	typedef struct packed {
		row_kind_e           kind;
		logic [VelWidth-1:0] vel_x;
		logic [VelWidth-1:0] vel_y;
		seek_item_t          it;
		seek_result_t        res;
	} row_t;

	localparam seek_result_t NONE = '0;

	// reset velocities hold until the first velocity row
	row_t dir_rows [22] = '{
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_TICK, 16'd256, 16'sd0, 16'sd0},
			'{32'sd0, 32'sd0, 1'b1, 1'b0}},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_TICK, 16'd0, 16'sd0, 16'sd0},
			'{32'sd0, 32'sd0, 1'b1, 1'b1}},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_UNUSED, 16'hFFFF, -16'sd1, -16'sd1},
			'{32'sd0, 32'sd0, 1'b1, 1'b0}},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_SET_TARGET, 16'd0, 16'sd3, 16'sd4},
			'{32'sd0, 32'sd0, 1'b0, 1'b0}},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'd256, 16'sd0, 16'sd0}, NONE},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'd0, 16'sd9, 16'sd9}, NONE},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'hFFFF, 16'sd0, 16'sd0}, NONE},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_SET_POS, 16'hFFFF, 16'sh8000, 16'sh7FFF},
			'{32'sh8000_0000, 32'sh7FFF_0000, 1'b1, 1'b0}},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_TICK, 16'd1, 16'sd0, 16'sd0},
			'{32'sh8000_0000, 32'sh7FFF_0000, 1'b1, 1'b0}},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_SET_TARGET, 16'd0, 16'sh7FFF, 16'sh8000},
			'{32'sh8000_0000, 32'sh7FFF_0000, 1'b0, 1'b0}},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'd1, 16'sd0, 16'sd0}, NONE},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'h0080, 16'sd0, 16'sd0}, NONE},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_UNUSED, 16'd0, 16'sh1234, -16'sd77}, NONE},
		'{ROW_VELOCITY, 16'hFFFF, 16'hFFFF, '0, NONE},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_SET_POS, 16'd0, 16'sh7FFF, 16'sh7FFF},
			'{32'sh7FFF_0000, 32'sh7FFF_0000, 1'b1, 1'b0}},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_SET_TARGET, 16'd0, 16'sh7FFF, -16'sd100},
			'{32'sh7FFF_0000, 32'sh7FFF_0000, 1'b0, 1'b0}},
		// full speed over unit time overshoots: y clamps at the negative limit
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'd1, 16'sd0, 16'sd0}, NONE},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'd1, 16'sd0, 16'sd0}, NONE},
		'{ROW_TYPED, 16'd0, 16'd0, '{OP_SET_POS, 16'd0, 16'sd32000, 16'sd0},
			'{32'sh7D00_0000, 32'sd0, 1'b1, 1'b0}},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_SET_TARGET, 16'd0, 16'sh7FFF, 16'sd0}, NONE},
		'{ROW_ITEM, 16'd0, 16'd0, '{OP_TICK, 16'd1, 16'sd0, 16'sd0}, NONE},
		'{ROW_VELOCITY, 16'd0, 16'd0, '0, NONE}
	};

	logic clk = 1'b0;
	logic arst_n;

	stps_item_if   item_bus ();
	stps_result_if result_bus ();
	stps_cfg_if    cfg_bus ();

	seek_target_position_step_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_bus),
		.result_out (result_bus),
		.cfg        (cfg_bus)
	);

	always #5 clk = ~clk;

	// predictor state
	logic signed [PosWidth-1:0] cur_x = '0;
	logic signed [PosWidth-1:0] cur_y = '0;
	logic signed [PosWidth-1:0] goal_x = '0;
	logic signed [PosWidth-1:0] goal_y = '0;
	logic                       goal_set = 1'b0;
	logic [VelWidth-1:0]        speed_x = VEL_RESET;
	logic [VelWidth-1:0]        speed_y = VEL_RESET;

	seek_result_t pending_results [$];
	seek_result_t predicted, want;
	seek_item_t   taken;
	logic         row_typed;
	seek_result_t row_expect;
	int           fault_count = 0;
	int           results_seen = 0;
	int           cycles = 0;
	bit           quiet = 1'b0;
	bit           held_off = 1'b0;

	function automatic logic [34:0] isqrt68(input logic [67:0] n);
		logic [34:0] root;
		logic [69:0] cand;
		root = '0;
		for (int b = 34; b >= 0; b--) begin
			cand = 70'(root | (35'd1 << b));
			if (cand * cand <= {2'b00, n})
				root = cand[34:0];
		end
		return root;
	endfunction

	function automatic logic signed [PosWidth-1:0] step_axis(
		input logic signed [PosWidth-1:0] p,
		input logic signed [32:0]         d,
		input logic [34:0]                len,
		input logic [VelWidth-1:0]        vel,
		input logic [TimeWidth-1:0]       t
	);
		logic [32:0]        mag;
		logic [63:0]        unit_dir, stride;
		logic signed [34:0] pe, se, moved;
		mag = d[32] ? 33'(-d) : 33'(d);
		unit_dir = ({31'd0, mag} << 30) / {29'd0, len};
		stride = (unit_dir * vel) / ({48'd0, t} << 14);
		pe = $signed({{3{p[PosWidth-1]}}, p});
		se = $signed({1'b0, stride[33:0]});
		moved = d[32] ? pe - se : pe + se;
		if (moved > 35'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (moved < -35'sd2147483648)
			return 32'sh8000_0000;
		return moved[PosWidth-1:0];
	endfunction

	function automatic seek_result_t seek_advance(input seek_item_t it);
		seek_result_t       r;
		logic signed [32:0] dx, dy;
		logic [32:0]        ax, ay;
		logic [67:0]        sumsq;
		logic [34:0]        len;
		r.bad_time = 1'b0;
		case (it.opcode)
		OP_TICK: begin
			if (it.time_step == '0) begin
				r.bad_time = 1'b1;
			end else if (goal_set) begin
				dx = $signed({goal_x[PosWidth-1], goal_x}) - $signed({cur_x[PosWidth-1], cur_x});
				dy = $signed({goal_y[PosWidth-1], goal_y}) - $signed({cur_y[PosWidth-1], cur_y});
				ax = dx[32] ? 33'(-dx) : 33'(dx);
				ay = dy[32] ? 33'(-dy) : 33'(dy);
				sumsq = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
				len = isqrt68(sumsq);
				if (len != '0) begin
					cur_x = step_axis(cur_x, dx, len, speed_x, it.time_step);
					cur_y = step_axis(cur_y, dy, len, speed_y, it.time_step);
				end
			end
		end
		OP_SET_POS: begin
			cur_x = {it.coord_x, 16'h0000};
			cur_y = {it.coord_y, 16'h0000};
			goal_x = {it.coord_x, 16'h0000};
			goal_y = {it.coord_y, 16'h0000};
			goal_set = 1'b1;
		end
		OP_SET_TARGET: begin
			goal_x = {it.coord_x, 16'h0000};
			goal_y = {it.coord_y, 16'h0000};
			goal_set = 1'b1;
		end
		default: ;
		endcase
		r.position_x = cur_x;
		r.position_y = cur_y;
		r.reached = !goal_set || (cur_x == goal_x && cur_y == goal_y);
		return r;
	endfunction

	function automatic logic signed [CoordWidth-1:0] rand_coord();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 100)) - 16'sd50;
	endfunction

	task automatic report(input string msg);
		fault_count++;
		if (fault_count <= 40)
			$display("tb: %s", msg);
	endtask

	// called just after a rising edge; returns at the edge that took the item, or after a random idle gap when not quiet
	task automatic offer(input seek_item_t it, input logic typed, input seek_result_t tr);
		item_bus.valid <= 1'b1;
		item_bus.opcode <= it.opcode;
		item_bus.time_step <= it.time_step;
		item_bus.coord_x <= it.coord_x;
		item_bus.coord_y <= it.coord_y;
		row_typed <= typed;
		row_expect <= tr;
		do @(posedge clk); while (!item_bus.ready);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_velocities(input logic [VelWidth-1:0] vx, input logic [VelWidth-1:0] vy);
		cfg_bus.valid <= 1'b1;
		cfg_bus.reg_index <= REG_VELOCITY_X;
		cfg_bus.wdata <= vx;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.reg_index <= REG_VELOCITY_Y;
		cfg_bus.wdata <= vy;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic run_phase(input int n);
		int                           sent, hops;
		seek_item_t                   it;
		logic signed [CoordWidth-1:0] home_x, home_y;
		sent = 0;
		home_x = '0;
		home_y = '0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 15) begin
				it = {2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom)};
				offer(it, 1'b0, NONE);
				if (it.opcode != OP_UNUSED)
					sent++;
			end else begin
				// journey: optional placement, a target, then a run of ticks
				if ($urandom_range(0, 3) != 0) begin
					home_x = rand_coord();
					home_y = rand_coord();
					it = {OP_SET_POS, 16'($urandom), home_x, home_y};
					offer(it, 1'b0, NONE);
					sent++;
				end
				it.opcode = OP_SET_TARGET;
				it.time_step = 16'($urandom);
				case ($urandom_range(0, 3))
				0: begin
					it.coord_x = home_x;
					it.coord_y = home_y;
				end
				1: begin
					it.coord_x = home_x + 16'($urandom_range(0, 6)) - 16'sd3;
					it.coord_y = home_y + 16'($urandom_range(0, 6)) - 16'sd3;
				end
				default: begin
					it.coord_x = rand_coord();
					it.coord_y = rand_coord();
				end
				endcase
				offer(it, 1'b0, NONE);
				sent++;
				hops = $urandom_range(1, 6);
				repeat (hops) begin
					it.opcode = OP_TICK;
					case ($urandom_range(0, 11))
					0: it.time_step = '0;
					1: it.time_step = 16'($urandom);
					2: it.time_step = 16'($urandom_range(1, 4));
					default: it.time_step = 16'($urandom_range(64, 1024));
					endcase
					it.coord_x = 16'($urandom);
					it.coord_y = 16'($urandom);
					offer(it, 1'b0, NONE);
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.reg_index)
				REG_VELOCITY_X: speed_x = cfg_bus.wdata;
				REG_VELOCITY_Y: speed_y = cfg_bus.wdata;
				default: ;
				endcase
			end
			// results first, so an item taken at the same edge cannot pair with it
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report($sformatf("result %0d arrived with nothing pending", results_seen));
				end else begin
					want = pending_results.pop_front();
					if (result_bus.position_x !== want.position_x)
						report($sformatf("result %0d position_x %0d, want %0d", results_seen,
							result_bus.position_x, want.position_x));
					if (result_bus.position_y !== want.position_y)
						report($sformatf("result %0d position_y %0d, want %0d", results_seen,
							result_bus.position_y, want.position_y));
					if (result_bus.reached !== want.reached)
						report($sformatf("result %0d reached %b, want %b", results_seen,
							result_bus.reached, want.reached));
					if (result_bus.bad_time !== want.bad_time)
						report($sformatf("result %0d bad_time %b, want %b", results_seen,
							result_bus.bad_time, want.bad_time));
				end
			end
			if (item_bus.valid && item_bus.ready) begin
				taken = {item_bus.opcode, item_bus.time_step, item_bus.coord_x, item_bus.coord_y};
				predicted = seek_advance(taken);
				pending_results.push_back(row_typed ? row_expect : predicted);
			end
		end
	end

	// result side: short random stalls, plus one long hold to back the block up
	initial begin
		result_bus.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= 150) begin
				held_off = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (900) @(posedge clk);
				result_bus.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				result_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				result_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [VelWidth-1:0] vx, vy;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.opcode = OP_TICK;
		item_bus.time_step = '0;
		item_bus.coord_x = '0;
		item_bus.coord_y = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.reg_index = REG_VELOCITY_X;
		cfg_bus.wdata = '0;
		row_typed = 1'b0;
		row_expect = NONE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_VELOCITY) begin
				drain();
				write_velocities(dir_rows[i].vel_x, dir_rows[i].vel_y);
			end else begin
				offer(dir_rows[i].it, dir_rows[i].kind == ROW_TYPED, dir_rows[i].res);
			end
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			0: begin vx = VEL_RESET; vy = VEL_RESET; end
			1: begin vx = '1; vy = '1; end
			2: begin vx = '0; vy = '0; end
			3: begin vx = 16'd1; vy = '1; end
			5: begin vx = 16'd256; vy = 16'd256; end
			6: begin vx = '1; vy = '0; end
			default: begin vx = 16'($urandom); vy = 16'($urandom); end
			endcase
			write_velocities(vx, vy);
			quiet = (ph == 7);
			run_phase(106);
			drain();
		end

		repeat (300) @(posedge clk);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/stps_pkg.sv
hw/rtl/stps_item_if.sv
hw/rtl/stps_result_if.sv
hw/rtl/stps_cfg_if.sv
hw/rtl/seek_target_position_step_top.sv
bench/tb.sv
